// ----- hdl/ptps_pkg.sv -----
// shared types, constants and helpers for the ptp slave offset servo
`default_nettype none

package ptps_pkg;

  localparam int MODE_W     = 2;
  localparam int TS_W       = 63;
  localparam int VAL_W      = 64;
  localparam int ALU_W      = 66;
  localparam int LIM_W      = 31;
  localparam int Q_W        = LIM_W + 1;
  localparam int GAIN_W     = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;

  localparam int RATIO_FRAC_BITS_DEF = 40;

  localparam logic [LIM_W-1:0]  DRIFT_LIMIT_RST = 31'd10995116;
  localparam logic [GAIN_W-1:0] GAIN_SHIFT_RST  = 5'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_DRIFT_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_SHIFT  = 1'd1;

  typedef enum logic [MODE_W-1:0] {
    MODE_T1 = 2'd0,
    MODE_T2 = 2'd1,
    MODE_T3 = 2'd2,
    MODE_T4 = 2'd3
  } mode_t;

  typedef enum logic {
    KIND_OFFSET = 1'b0,
    KIND_FREQ   = 1'b1
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_S2M,
    ST_MEAN,
    ST_M2S,
    ST_OFS,
    ST_DTS,
    ST_DEN,
    ST_EMIT_OFS,
    ST_NUM1,
    ST_NUM2,
    ST_ABS,
    ST_DIV,
    ST_SIGN,
    ST_EMIT_FRQ
  } state_t;

  // one request to the shared adder
  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

  function automatic logic [ALU_W-1:0] zext_ts(input logic [TS_W-1:0] v);
    zext_ts = {{(ALU_W-TS_W){1'b0}}, v};
  endfunction

  function automatic logic [ALU_W-1:0] sext_val(input logic [VAL_W-1:0] v);
    sext_val = {{(ALU_W-VAL_W){v[VAL_W-1]}}, v};
  endfunction

endpackage

`default_nettype wire

// ----- hdl/ptps_if.sv -----
// valid/ready channel interfaces for timestamp events and adjustment results
`default_nettype none

interface ptps_in_if;
  logic                        valid;
  logic                        ready;
  logic [ptps_pkg::MODE_W-1:0] mode;
  logic [ptps_pkg::TS_W-1:0]   timestamp;

  modport source (output valid, output mode, output timestamp, input ready);
  modport sink   (input valid, input mode, input timestamp, output ready);
endinterface

interface ptps_out_if;
  logic                              valid;
  logic                              ready;
  logic                              adjust_kind;
  logic signed [ptps_pkg::VAL_W-1:0] adjust_value;
  logic                              last;

  modport source (output valid, output adjust_kind, output adjust_value, output last,
                  input ready);
  modport sink   (input valid, input adjust_kind, input adjust_value, input last,
                  output ready);
endinterface

`default_nettype wire

// ----- hdl/ptp_slave_offset_servo_core.sv -----
// ptp slave servo: path delay, offset and drift-based frequency adjustment
//
//   channel   direction  payload                                  transfer when
//   in_ch     in         mode[1:0], timestamp[62:0]               valid && ready
//   out_ch    out        adjust_kind, adjust_value[63:0], last    valid && ready
//   cfg_*     in         cfg_index[0], cfg_wdata[30:0]            cfg_we
//
// T1 and T3 events store their timestamp; T4 forms the slave-to-master delay and
// the mean path delay. T2 forms the offset and waits for the output slot, and
// when a frequency result follows, it runs the one-bit-per-cycle restoring
// division on the shared adder.
// The division ends early once the quotient passes drift_limit.
// rst_n is synchronous; it clears the servo state and loads register defaults.
// in_ch.ready is low while an event is in work; out_ch stalls hold the sequencer.
`default_nettype none

module ptp_slave_offset_servo_core #(
  parameter int RATIO_FRAC_BITS = ptps_pkg::RATIO_FRAC_BITS_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  ptps_in_if.sink                               in_ch,
  ptps_out_if.source                            out_ch,
  input  wire                                   cfg_we,
  input  wire [ptps_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire [ptps_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
  import ptps_pkg::*;

  localparam int NUM_W = ALU_W + RATIO_FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W);

  state_t state_r, state_nxt;

  logic [LIM_W-1:0]  drift_limit_r;
  logic [GAIN_W-1:0] gain_shift_r;

  logic [TS_W-1:0]   ts_r;
  logic [TS_W-1:0]   mst_r;
  logic [TS_W-1:0]   lrt_r;
  logic [TS_W-1:0]   pmt_r;
  logic [TS_W-1:0]   plt_r;
  logic [VAL_W-1:0]  m2s_r;
  logic [VAL_W-1:0]  s2m_r;
  logic [VAL_W-1:0]  mean_r;
  logic [VAL_W-1:0]  y_r;
  logic [TS_W-1:0]   den_r;
  logic              freq_ok_r;
  logic [ALU_W-1:0]  acc_r;
  logic              neg_r;
  logic [NUM_W-1:0]  dvd_r;
  logic [TS_W-1:0]   rem_r;
  logic [LIM_W-1:0]  q_r;
  logic              sat_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [Q_W-1:0]    d_r;

  logic              out_valid_r;
  logic              out_kind_r;
  logic [VAL_W-1:0]  out_value_r;
  logic              out_last_r;

  alu_req_t          alu_req;
  logic [ALU_W-1:0]  alu_res;

  logic              in_fire;
  logic              slot_free;
  logic              out_load;
  logic              div_ge;
  logic [Q_W-1:0]    q_next;
  logic              q_over;
  logic [LIM_W-1:0]  mag;
  logic [VAL_W-1:0]  y_sat;
  logic [Q_W-1:0]    d_shift;

  ptps_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign out_load  = ((state_r == ST_EMIT_OFS) || (state_r == ST_EMIT_FRQ)) && slot_free;

  // division step: trial subtract of den from {rem, next dividend bit}
  assign div_ge = !alu_res[ALU_W-1];
  assign q_next = {q_r, div_ge};
  assign q_over = q_next > {1'b0, drift_limit_r};
  assign mag    = sat_r ? drift_limit_r : q_r;

  // saturate the 65-bit difference to the signed 64-bit range
  assign y_sat = (alu_res[VAL_W] != alu_res[VAL_W-1]) ?
                 (alu_res[ALU_W-1] ? {1'b1, {(VAL_W-1){1'b0}}}
                                   : {1'b0, {(VAL_W-1){1'b1}}}) :
                 alu_res[VAL_W-1:0];

  assign d_shift = $signed(d_r) >>> gain_shift_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.mode == MODE_T2) state_nxt = ST_M2S;
          else if (in_ch.mode == MODE_T4) state_nxt = ST_S2M;
        end
      end
      ST_S2M:      state_nxt = ST_MEAN;
      ST_MEAN:     state_nxt = ST_IDLE;
      ST_M2S:      state_nxt = ST_OFS;
      ST_OFS:      state_nxt = ST_DTS;
      ST_DTS:      state_nxt = ST_DEN;
      ST_DEN:      state_nxt = ST_EMIT_OFS;
      ST_EMIT_OFS: begin
        if (slot_free) state_nxt = freq_ok_r ? ST_NUM1 : ST_IDLE;
      end
      ST_NUM1:     state_nxt = ST_NUM2;
      ST_NUM2:     state_nxt = ST_ABS;
      ST_ABS:      state_nxt = ST_DIV;
      ST_DIV: begin
        if (q_over || cnt_r == '0) state_nxt = ST_SIGN;
      end
      ST_SIGN:     state_nxt = ST_EMIT_FRQ;
      ST_EMIT_FRQ: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // outputs: handshake and shared adder operands
  always_comb begin
    in_ch.ready = (state_r == ST_IDLE);
    alu_req.a   = '0;
    alu_req.b   = '0;
    alu_req.sub = 1'b0;
    unique case (state_r)
      ST_S2M: begin
        alu_req.a   = zext_ts(ts_r);
        alu_req.b   = zext_ts(lrt_r);
        alu_req.sub = 1'b1;
      end
      ST_MEAN: begin
        alu_req.a = sext_val(m2s_r);
        alu_req.b = sext_val(s2m_r);
      end
      ST_M2S: begin
        alu_req.a   = zext_ts(ts_r);
        alu_req.b   = zext_ts(mst_r);
        alu_req.sub = 1'b1;
      end
      ST_OFS: begin
        alu_req.a   = sext_val(m2s_r);
        alu_req.b   = sext_val(mean_r);
        alu_req.sub = 1'b1;
      end
      ST_DTS: begin
        alu_req.a   = zext_ts(ts_r);
        alu_req.b   = zext_ts(plt_r);
        alu_req.sub = 1'b1;
      end
      ST_DEN: begin
        alu_req.a   = zext_ts(mst_r);
        alu_req.b   = zext_ts(pmt_r);
        alu_req.sub = 1'b1;
      end
      ST_NUM1: begin
        alu_req.a = acc_r;
        alu_req.b = sext_val(y_r);
      end
      ST_NUM2: begin
        alu_req.a   = acc_r;
        alu_req.b   = zext_ts(den_r);
        alu_req.sub = 1'b1;
      end
      ST_ABS: begin
        alu_req.b   = acc_r;
        alu_req.sub = acc_r[ALU_W-1];
      end
      ST_DIV: begin
        alu_req.a   = {{(ALU_W-TS_W-1){1'b0}}, rem_r, dvd_r[NUM_W-1]};
        alu_req.b   = zext_ts(den_r);
        alu_req.sub = 1'b1;
      end
      ST_SIGN: begin
        alu_req.b   = {{(ALU_W-LIM_W){1'b0}}, mag};
        alu_req.sub = neg_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      drift_limit_r <= DRIFT_LIMIT_RST;
      gain_shift_r  <= GAIN_SHIFT_RST;
      mst_r         <= '0;
      lrt_r         <= '0;
      pmt_r         <= '0;
      plt_r         <= '0;
      m2s_r         <= '0;
      s2m_r         <= '0;
      mean_r        <= '0;
      freq_ok_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DRIFT_LIMIT: drift_limit_r <= cfg_wdata[LIM_W-1:0];
          CFG_GAIN_SHIFT:  gain_shift_r  <= cfg_wdata[GAIN_W-1:0];
          default: begin
          end
        endcase
      end

      if (out_load)          out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            ts_r <= in_ch.timestamp;
            if (in_ch.mode == MODE_T1) mst_r <= in_ch.timestamp;
            if (in_ch.mode == MODE_T3) lrt_r <= in_ch.timestamp;
          end
        end
        ST_S2M:  s2m_r  <= alu_res[VAL_W-1:0];
        ST_MEAN: mean_r <= alu_res[VAL_W:1];
        ST_M2S:  m2s_r  <= alu_res[VAL_W-1:0];
        ST_OFS:  y_r    <= y_sat;
        ST_DTS:  acc_r  <= alu_res;
        ST_DEN: begin
          den_r     <= alu_res[TS_W-1:0];
          freq_ok_r <= (pmt_r != '0) && !alu_res[ALU_W-1] && (alu_res != '0);
          pmt_r     <= mst_r;
          plt_r     <= ts_r;
        end
        ST_EMIT_OFS: begin
          if (slot_free) begin
            out_kind_r  <= KIND_OFFSET;
            out_value_r <= y_r;
            out_last_r  <= !freq_ok_r;
          end
        end
        ST_NUM1: acc_r <= alu_res;
        ST_NUM2: acc_r <= alu_res;
        ST_ABS: begin
          neg_r <= acc_r[ALU_W-1];
          dvd_r <= {alu_res, {RATIO_FRAC_BITS{1'b0}}};
          rem_r <= '0;
          q_r   <= '0;
          sat_r <= 1'b0;
          cnt_r <= CNT_W'(NUM_W - 1);
        end
        ST_DIV: begin
          dvd_r <= {dvd_r[NUM_W-2:0], 1'b0};
          cnt_r <= cnt_r - 1'b1;
          if (div_ge) rem_r <= alu_res[TS_W-1:0];
          else        rem_r <= {rem_r[TS_W-2:0], dvd_r[NUM_W-1]};
          if (q_over) sat_r <= 1'b1;
          else        q_r   <= q_next[LIM_W-1:0];
        end
        ST_SIGN: d_r <= alu_res[Q_W-1:0];
        ST_EMIT_FRQ: begin
          if (slot_free) begin
            out_kind_r  <= KIND_FREQ;
            out_value_r <= {{(VAL_W-Q_W){d_shift[Q_W-1]}}, d_shift};
            out_last_r  <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.adjust_kind  = out_kind_r;
  assign out_ch.adjust_value = out_value_r;
  assign out_ch.last         = out_last_r;

endmodule

`default_nettype wire

// ----- hdl/ptps_alu.sv -----
// shared 66-bit add/subtract unit used by every arithmetic step of the sequencer
`default_nettype none

module ptps_alu (
  input  ptps_pkg::alu_req_t          req,
  output logic [ptps_pkg::ALU_W-1:0]  res
);
  import ptps_pkg::*;

  logic [ALU_W-1:0] b_in;

  assign b_in = req.sub ? ~req.b : req.b;
  assign res  = req.a + b_in + {{(ALU_W-1){1'b0}}, req.sub};

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// self-checking testbench for the ptp slave offset and frequency servo
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ptps_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  // slowest t2: the offset steps, then the drift division, plus output stalls
  localparam int DRAIN_CYCLES = 150;
  localparam logic [TS_W-1:0] TS_MAX = '1;
  localparam logic [LIM_W-1:0] LIM_MAX = '1;
  localparam logic [GAIN_W-1:0] SHIFT_MAX = '1;

  typedef struct packed {
    kind_t            kind;
    logic [VAL_W-1:0] value;
    logic             last;
  } adjust_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ptps_in_if  in_ch ();
  ptps_out_if out_ch ();

  ptp_slave_offset_servo_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // servo state as the block should hold it
  logic [TS_W-1:0]  mst_sync_ts, req_ts, prev_mst_ts, prev_loc_ts;
  logic [VAL_W-1:0] m2s_dly, s2m_dly, mean_dly;
  logic [LIM_W-1:0] lim_reg;
  logic [GAIN_W-1:0] shift_reg;

  adjust_t pending_adjusts[$];
  int error_count = 0;
  int events_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  function automatic logic [TS_W-1:0] rand_ts();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TS_W-1:0];
  endfunction

  // works out the adjustments caused by one accepted event
  task automatic servo_predict(input mode_t m, input logic [TS_W-1:0] ts);
    logic [VAL_W:0] wide;
    logic [VAL_W-1:0] ofs, loc_dt, drift;
    logic signed [VAL_W-1:0] freq_word;
    logic [TS_W-1:0] den;
    logic [127:0] num, quo;
    logic neg, has_freq;
    case (m)
      MODE_T1: mst_sync_ts = ts;
      MODE_T3: req_ts = ts;
      MODE_T4: begin
        s2m_dly = {1'b0, ts} - {1'b0, req_ts};
        // exact sum, halved toward minus infinity
        wide = {m2s_dly[VAL_W-1], m2s_dly} + {s2m_dly[VAL_W-1], s2m_dly};
        mean_dly = wide[VAL_W:1];
      end
      MODE_T2: begin
        m2s_dly = {1'b0, ts} - {1'b0, mst_sync_ts};
        wide = {m2s_dly[VAL_W-1], m2s_dly} - {mean_dly[VAL_W-1], mean_dly};
        if (wide[VAL_W] != wide[VAL_W-1]) begin
          ofs = wide[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end else begin
          ofs = wide[VAL_W-1:0];
        end
        has_freq = (prev_mst_ts != '0) && (mst_sync_ts > prev_mst_ts);
        pending_adjusts.push_back('{KIND_OFFSET, ofs, !has_freq});
        if (has_freq) begin
          den = mst_sync_ts - prev_mst_ts;
          loc_dt = {1'b0, ts} - {1'b0, prev_loc_ts};
          num = {{64{loc_dt[63]}}, loc_dt} + {{64{ofs[63]}}, ofs} - {65'd0, den};
          neg = num[127];
          if (neg) num = -num;
          quo = (num << RATIO_FRAC_BITS_DEF) / {65'd0, den};
          drift = (quo > {97'd0, lim_reg}) ? {33'd0, lim_reg} : quo[63:0];
          if (neg) drift = -drift;
          freq_word = $signed(drift) >>> shift_reg;
          pending_adjusts.push_back('{KIND_FREQ, freq_word, 1'b1});
        end
        prev_mst_ts = mst_sync_ts;
        prev_loc_ts = ts;
      end
    endcase
  endtask

  task automatic send_event(input mode_t m, input logic [TS_W-1:0] ts);
    int gap;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 24) : $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= m;
    in_ch.timestamp <= ts;
    do @(posedge clk); while (!in_ch.ready);
    servo_predict(m, ts);
    events_sent++;
  endtask

  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_adjusts.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_DRIFT_LIMIT) lim_reg = data[LIM_W-1:0];
    else shift_reg = data[GAIN_W-1:0];
  endtask

  task automatic set_servo_cfg(input logic [LIM_W-1:0] lim, input logic [GAIN_W-1:0] shift);
    hold_until_drained();
    // a trailing t4 may still be in work after the last adjustment
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(CFG_DRIFT_LIMIT, CFG_DATA_W'(lim));
    write_reg(CFG_GAIN_SHIFT, CFG_DATA_W'(shift));
  endtask

  // sync/delay-request exchanges between drifting clocks, with noise and broken rounds
  task automatic run_sync_rounds(input int n_items);
    int stop_at, skip, first, k;
    longint di, corr, rate_ppb;
    logic [TS_W-1:0] mt, lt;
    mode_t ev_mode [4];
    logic [TS_W-1:0] ev_ts [4];
    stop_at = events_sent + n_items;
    mt = rand_ts() >> $urandom_range(0, 24);
    lt = mt + $urandom_range(0, 1000);
    rate_ppb = longint'($urandom_range(0, 40000)) - 20000;
    ev_mode = '{MODE_T1, MODE_T2, MODE_T3, MODE_T4};
    while (events_sent < stop_at) begin
      if ($urandom_range(0, 99) < 15) begin
        send_event(mode_t'($urandom_range(0, 3)),
                   $urandom_range(0, 1) ? rand_ts() : mt + $urandom_range(0, 1000000));
      end else begin
        case ($urandom_range(0, 9))
          0, 1:    di = $urandom_range(1, 1000);
          8, 9:    di = longint'($urandom) << $urandom_range(0, 8);
          default: di = $urandom_range(1000000, 1000000000);
        endcase
        if ($urandom_range(0, 19) == 0) rate_ppb = longint'($urandom_range(0, 40000)) - 20000;
        // clock step brings the local clock back onto the master
        if ($urandom_range(0, 4) == 0) lt = mt;
        corr = (di / 1000) * rate_ppb / 1000000;
        mt += TS_W'(di);
        lt += TS_W'(di + corr);
        ev_ts[0] = mt;
        ev_ts[1] = lt + $urandom_range(0, 5000);
        ev_ts[2] = ev_ts[1] + $urandom_range(10, 100000);
        ev_ts[3] = ev_ts[2] - lt + mt + $urandom_range(0, 5000);
        skip = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 3) : 4;
        first = ($urandom_range(0, 3) == 0) ? 2 : 0;
        for (int i = 0; i < 4; i++) begin
          k = (i + first) % 4;
          if (k != skip) send_event(ev_mode[k], ev_ts[k]);
        end
        if ($urandom_range(0, 59) == 0) hold_until_drained();
      end
    end
  endtask

  task automatic test_directed_events();
    send_event(MODE_T2, 100);           // no sync seen yet
    send_event(MODE_T1, 1000);
    send_event(MODE_T2, 1500);          // previous master time still zero
    send_event(MODE_T3, 2000);
    send_event(MODE_T4, 2300);
    send_event(MODE_T1, 1001000);
    send_event(MODE_T2, 1001600);       // drift clamps positive
    send_event(MODE_T1, 2001000);
    send_event(MODE_T2, 2001498);       // small negative drift, gain rounds down
    send_event(MODE_T1, 2001000);
    send_event(MODE_T2, 2001700);       // master interval zero
    send_event(MODE_T1, 1500000);
    send_event(MODE_T2, 1600000);       // master interval negative
    send_event(MODE_T1, TS_MAX);
    send_event(MODE_T2, 0);
    send_event(MODE_T3, TS_MAX);
    send_event(MODE_T4, 0);             // mean goes to the negative extreme
    send_event(MODE_T1, 0);
    send_event(MODE_T2, TS_MAX);        // offset saturates high
    send_event(MODE_T3, 0);
    send_event(MODE_T4, TS_MAX);
    send_event(MODE_T1, TS_MAX);
    send_event(MODE_T2, 0);             // offset saturates low
    send_event(MODE_T3, 7);
    send_event(MODE_T4, 2);             // negative sum below the 64-bit range in the mean
  endtask

  task automatic test_wide_limit_unity_gain();
    set_servo_cfg(LIM_MAX, '0);
    run_sync_rounds(400);
  endtask

  task automatic test_zero_limit_max_gain();
    set_servo_cfg('0, SHIFT_MAX);
    run_sync_rounds(200);
  endtask

  task automatic test_wide_limit_max_gain();
    set_servo_cfg(LIM_MAX, SHIFT_MAX);
    run_sync_rounds(300);
  endtask

  task automatic test_random_settings();
    logic [LIM_W-1:0] lim;
    repeat (3) begin
      lim = $urandom_range(0, 1) ? LIM_W'($urandom) : LIM_W'($urandom_range(1, 100000000));
      set_servo_cfg(lim, GAIN_W'($urandom_range(0, 31)));
      run_sync_rounds(200);
    end
  endtask

  task automatic test_reset_settings();
    set_servo_cfg(DRIFT_LIMIT_RST, GAIN_SHIFT_RST);
    run_sync_rounds(300);
  endtask

  // receiver: random short stalls with calm stretches
  initial begin : ready_pattern
    int stall_left, calm_left;
    out_ch.ready <= 1'b0;
    stall_left = 0;
    calm_left = 0;
    forever begin
      @(posedge clk);
      if (calm_left > 0) begin
        calm_left--;
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        case ($urandom_range(0, 15))
          0:       calm_left = $urandom_range(200, 800);
          1, 2, 3: stall_left = $urandom_range(1, 12);
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    adjust_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_adjusts.size() == 0) begin
        $error("unexpected adjustment: kind %0d value %0d last %0d",
               out_ch.adjust_kind, $signed(out_ch.adjust_value), out_ch.last);
        error_count++;
      end else begin
        want = pending_adjusts.pop_front();
        if (out_ch.adjust_kind !== want.kind) begin
          $error("adjust_kind: expected %0d actual %0d", want.kind, out_ch.adjust_kind);
          error_count++;
        end
        if (out_ch.adjust_value !== want.value) begin
          $error("adjust_value: expected %0d actual %0d",
                 $signed(want.value), $signed(out_ch.adjust_value));
          error_count++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0d actual %0d", want.last, out_ch.last);
          error_count++;
        end
      end
    end
  end

  // counts cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_DRIFT_LIMIT;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.mode      <= MODE_T1;
    in_ch.timestamp <= '0;
    lim_reg     = DRIFT_LIMIT_RST;
    shift_reg   = GAIN_SHIFT_RST;
    mst_sync_ts = '0;
    req_ts      = '0;
    prev_mst_ts = '0;
    prev_loc_ts = '0;
    m2s_dly     = '0;
    s2m_dly     = '0;
    mean_dly    = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_events();
    test_wide_limit_unity_gain();
    test_zero_limit_max_gain();
    test_wide_limit_max_gain();
    test_random_settings();
    test_reset_settings();

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_adjusts.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/ptps_pkg.sv
hdl/ptps_if.sv
hdl/ptps_alu.sv
hdl/ptp_slave_offset_servo_core.sv
sim/testbench.sv
